[hdl/qvr_pkg.sv]
`default_nettype none

package qvr_pkg;

  // Register stages inside one product-and-sum lane
  localparam int LANE_LATENCY = 2;

  // Input register, two lane passes, saturation register
  localparam int PIPE_LATENCY = 2 * LANE_LATENCY + 2;

endpackage

`default_nettype wire

[hdl/qvr_lane.sv]
`default_nettype none

// One output component: four signed products, added or subtracted,
// then rounded to nearest at FRAC fraction bits. Sums wrap at SW bits.
module qvr_lane #(
  parameter int       AW   = 16,
  parameter int       BW   = 16,
  parameter int       SW   = 34,
  parameter int       FRAC = 14,
  parameter bit [3:0] NEG  = 4'b0000
) (
  input  wire logic                   clk,
  input  wire logic signed [AW-1:0]   in_a [4],
  input  wire logic signed [BW-1:0]   in_b [4],
  output logic        [SW-FRAC-1:0]   rnd_r
);

  localparam int PW = AW + BW;
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC - 1);

  logic signed [PW-1:0] prod_full [4];
  logic        [SW-1:0] prod_nxt  [4];
  logic        [SW-1:0] prod_r    [4];
  logic        [SW-1:0] sum;
  logic        [SW-1:0] sum_rnd;
  logic   [SW-FRAC-1:0] rnd_nxt;

  // Multipliers, fitted to the accumulator width (sign extend or wrap)
  for (genvar i = 0; i < 4; i++) begin : g_mul
    assign prod_full[i] = in_a[i] * in_b[i];
    if (SW >= PW) begin : g_ext
      assign prod_nxt[i] = SW'(prod_full[i]);
    end else begin : g_wrap
      assign prod_nxt[i] = prod_full[i][SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Signed sum and round half up
  always_comb begin
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      if (NEG[i]) begin
        sum = sum - prod_r[i];
      end else begin
        sum = sum + prod_r[i];
      end
    end
    sum_rnd = sum + HALF;
    rnd_nxt = sum_rnd[SW-1:FRAC];
  end

  always_ff @(posedge clk) begin
    rnd_r <= rnd_nxt;
  end

endmodule

`default_nettype wire

[hdl/quaternion_vector_rotate.sv]
`default_nettype none

// Rotates a vector by a quaternion as q * (v,0) * conj(q), rounding to
// nearest after each Hamilton product and saturating the result to
// DATA_WIDTH bits (out_saturated flags any clipped component). q is used as
// given, with no normalization. The block takes one beat per clock: busy is
// high only during reset and the cycle after it, and each accepted beat
// comes out on out_valid after the input register, two multiply/sum lanes
// of 2 stages each and the saturation register. The receiver cannot
// stall, so results appear in input order with a fixed latency.
module quaternion_vector_rotate
  import qvr_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] in_quat_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_quat_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_quat_z,
  input  wire logic signed [DATA_WIDTH-1:0] in_quat_w,
  input  wire logic signed [DATA_WIDTH-1:0] in_vec_x,
  input  wire logic signed [DATA_WIDTH-1:0] in_vec_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_vec_z,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_rot_x,
  output logic signed [DATA_WIDTH-1:0]      out_rot_y,
  output logic signed [DATA_WIDTH-1:0]      out_rot_z,
  output logic                              out_saturated
);

  localparam int DW  = DATA_WIDTH;
  localparam int S1W = (2 * DW + 2 > 64) ? 64 : 2 * DW + 2;
  localparam int TW  = S1W - FRAC_BITS;
  localparam int S2W = (TW + DW + 2 > 64) ? 64 : TW + DW + 2;
  localparam int RW  = S2W - FRAC_BITS;

  logic                  busy_r;
  logic                  accept;
  logic [PIPE_LATENCY-1:0] vld_r;

  logic signed [DW-1:0]  q_r [4];   // x, y, z, w
  logic signed [DW-1:0]  v_r [3];
  logic signed [DW-1:0]  q_d_r [LANE_LATENCY][4];

  logic signed [DW-1:0]  l1_a [4][4];
  logic signed [DW-1:0]  l1_b [4][4];
  logic       [TW-1:0]   t_r  [4];  // x, y, z, w
  logic signed [TW-1:0]  l2_a [3][4];
  logic signed [DW-1:0]  l2_b [3][4];
  logic       [RW-1:0]   u_r  [3];

  logic signed [DW-1:0]  rot_nxt [3];
  logic        [2:0]     clip;
  logic signed [DW-1:0]  rot_r [3];
  logic                  sat_r;

  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  // Busy through reset and the cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[PIPE_LATENCY-2:0], accept};
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    q_r <= '{in_quat_x, in_quat_y, in_quat_z, in_quat_w};
    v_r <= '{in_vec_x, in_vec_y, in_vec_z};
  end

  // q delay line to meet t at the second product
  always_ff @(posedge clk) begin
    q_d_r[0] <= q_r;
    for (int i = 1; i < LANE_LATENCY; i++) begin
      q_d_r[i] <= q_d_r[i-1];
    end
  end

  // t = q * (v,0): term order per lane, fourth term unused in every lane
  assign l1_a[0] = '{q_r[1], q_r[2], q_r[3], '0};
  assign l1_b[0] = '{v_r[2], v_r[1], v_r[0], '0};
  assign l1_a[1] = '{q_r[2], q_r[0], q_r[3], '0};
  assign l1_b[1] = '{v_r[0], v_r[2], v_r[1], '0};
  assign l1_a[2] = '{q_r[0], q_r[1], q_r[3], '0};
  assign l1_b[2] = '{v_r[1], v_r[0], v_r[2], '0};
  assign l1_a[3] = '{q_r[0], q_r[1], q_r[2], '0};
  assign l1_b[3] = '{v_r[0], v_r[1], v_r[2], '0};

  for (genvar c = 0; c < 4; c++) begin : g_first
    qvr_lane #(
      .AW   (DW),
      .BW   (DW),
      .SW   (S1W),
      .FRAC (FRAC_BITS),
      .NEG  ((c == 3) ? 4'b0111 : 4'b0010)
    ) u_lane (
      .clk   (clk),
      .in_a  (l1_a[c]),
      .in_b  (l1_b[c]),
      .rnd_r (t_r[c])
    );
  end

  // u = t * conj(q), vector part
  assign l2_a[0] = '{t_r[2], t_r[1], t_r[0], t_r[3]};
  assign l2_b[0] = '{q_d_r[LANE_LATENCY-1][1], q_d_r[LANE_LATENCY-1][2],
                     q_d_r[LANE_LATENCY-1][3], q_d_r[LANE_LATENCY-1][0]};
  assign l2_a[1] = '{t_r[0], t_r[2], t_r[1], t_r[3]};
  assign l2_b[1] = '{q_d_r[LANE_LATENCY-1][2], q_d_r[LANE_LATENCY-1][0],
                     q_d_r[LANE_LATENCY-1][3], q_d_r[LANE_LATENCY-1][1]};
  assign l2_a[2] = '{t_r[1], t_r[0], t_r[2], t_r[3]};
  assign l2_b[2] = '{q_d_r[LANE_LATENCY-1][0], q_d_r[LANE_LATENCY-1][1],
                     q_d_r[LANE_LATENCY-1][3], q_d_r[LANE_LATENCY-1][2]};

  for (genvar c = 0; c < 3; c++) begin : g_second
    qvr_lane #(
      .AW   (TW),
      .BW   (DW),
      .SW   (S2W),
      .FRAC (FRAC_BITS),
      .NEG  (4'b1010)
    ) u_lane (
      .clk   (clk),
      .in_a  (l2_a[c]),
      .in_b  (l2_b[c]),
      .rnd_r (u_r[c])
    );
  end

  // Saturate to DATA_WIDTH: in range when all bits above the sign agree
  for (genvar c = 0; c < 3; c++) begin : g_sat
    if (RW > DW) begin : g_clip
      always_comb begin
        if ((&u_r[c][RW-1:DW-1]) || !(|u_r[c][RW-1:DW-1])) begin
          clip[c]    = 1'b0;
          rot_nxt[c] = u_r[c][DW-1:0];
        end else begin
          clip[c]    = 1'b1;
          rot_nxt[c] = u_r[c][RW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
      end
    end else begin : g_pass
      assign clip[c]    = 1'b0;
      assign rot_nxt[c] = DW'(signed'(u_r[c]));
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
    sat_r <= |clip;
  end

  assign out_valid     = vld_r[PIPE_LATENCY-1];
  assign out_rot_x     = rot_r[0];
  assign out_rot_y     = rot_r[1];
  assign out_rot_z     = rot_r[2];
  assign out_saturated = sat_r;

endmodule

`default_nettype wire

[hdl/qvr_checker.sv]
`default_nettype none

module qvr_checker
  import qvr_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  out_valid,
  input wire logic [DATA_WIDTH-1:0] out_rot_x,
  input wire logic [DATA_WIDTH-1:0] out_rot_y,
  input wire logic [DATA_WIDTH-1:0] out_rot_z,
  input wire logic                  out_saturated
);

  localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Every accepted beat comes out after the fixed latency
  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid)
    else $error("accepted beat did not come out");

  // No result without an accepted beat
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##PIPE_LATENCY !out_valid)
    else $error("result without accepted beat");

  // A saturated result has a component at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_rot_x == MAXV || out_rot_x == MINV || out_rot_y == MAXV ||
       out_rot_y == MINV || out_rot_z == MAXV || out_rot_z == MINV))
    else $error("saturated flag with no clipped component");

  // Reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && busy))
    else $error("pipeline not flushed by reset");

endmodule

bind quaternion_vector_rotate qvr_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qvr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_rot_x     (out_rot_x),
  .out_rot_y     (out_rot_y),
  .out_rot_z     (out_rot_z),
  .out_saturated (out_saturated)
);

`default_nettype wire

[sim/quaternion_vector_rotate_checker.sv]
// Watches both channels of the rotator, predicts each result and compares it
module quaternion_vector_rotate_checker #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_quat_x,
  input  logic signed [DATA_WIDTH-1:0] in_quat_y,
  input  logic signed [DATA_WIDTH-1:0] in_quat_z,
  input  logic signed [DATA_WIDTH-1:0] in_quat_w,
  input  logic signed [DATA_WIDTH-1:0] in_vec_x,
  input  logic signed [DATA_WIDTH-1:0] in_vec_y,
  input  logic signed [DATA_WIDTH-1:0] in_vec_z,
  input  logic                         out_valid,
  input  logic signed [DATA_WIDTH-1:0] out_rot_x,
  input  logic signed [DATA_WIDTH-1:0] out_rot_y,
  input  logic signed [DATA_WIDTH-1:0] out_rot_z,
  input  logic                         out_saturated,
  output int                           mismatch_count,
  output int                           pending
);

  typedef struct packed {
    logic [DATA_WIDTH-1:0] x;
    logic [DATA_WIDTH-1:0] y;
    logic [DATA_WIDTH-1:0] z;
    logic                  sat;
  } rot_t;

  localparam longint OUT_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  rot_t expected_rots[$];
  int   err_cnt = 0;
  int   wait_cnt = 0;

  assign mismatch_count = err_cnt;
  assign pending        = wait_cnt;

  // round to nearest, ties go up
  function automatic longint round_frac(input longint v);
    return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] clip(input longint v);
    if (v > OUT_MAX) return OUT_MAX[DATA_WIDTH-1:0];
    if (v < OUT_MIN) return OUT_MIN[DATA_WIDTH-1:0];
    return v[DATA_WIDTH-1:0];
  endfunction

  // q * (v,0) * conj(q), rounded after each product, then clipped
  function automatic rot_t rotate_by_quat(
    input longint qx, input longint qy, input longint qz, input longint qw,
    input longint vx, input longint vy, input longint vz
  );
    longint tx, ty, tz, tw, ux, uy, uz;
    rot_t   r;
    tx = round_frac(qy * vz - qz * vy + qw * vx);
    ty = round_frac(qz * vx - qx * vz + qw * vy);
    tz = round_frac(qx * vy - qy * vx + qw * vz);
    tw = round_frac(-(qx * vx + qy * vy + qz * vz));
    ux = round_frac(tz * qy - ty * qz + qw * tx - tw * qx);
    uy = round_frac(tx * qz - tz * qx + qw * ty - tw * qy);
    uz = round_frac(ty * qx - tx * qy + qw * tz - tw * qz);
    r.x   = clip(ux);
    r.y   = clip(uy);
    r.z   = clip(uz);
    r.sat = (ux > OUT_MAX) || (ux < OUT_MIN) || (uy > OUT_MAX) || (uy < OUT_MIN) ||
            (uz > OUT_MAX) || (uz < OUT_MIN);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rot_t want;
    if (rst_n) begin
      // result beat: compare with the oldest prediction
      if (out_valid) begin
        if (expected_rots.size() == 0) begin
          $display("%0t: unexpected result beat x=%0d y=%0d z=%0d sat=%0b", $time,
                   out_rot_x, out_rot_y, out_rot_z, out_saturated);
          err_cnt++;
        end else begin
          want = expected_rots.pop_front();
          if (out_rot_x !== want.x) begin
            $display("%0t: rot_x expected %0d got %0d", $time,
                     $signed(want.x), out_rot_x);
            err_cnt++;
          end
          if (out_rot_y !== want.y) begin
            $display("%0t: rot_y expected %0d got %0d", $time,
                     $signed(want.y), out_rot_y);
            err_cnt++;
          end
          if (out_rot_z !== want.z) begin
            $display("%0t: rot_z expected %0d got %0d", $time,
                     $signed(want.z), out_rot_z);
            err_cnt++;
          end
          if (out_saturated !== want.sat) begin
            $display("%0t: saturated expected %0b got %0b", $time,
                     want.sat, out_saturated);
            err_cnt++;
          end
        end
      end
      // input beat taken: queue its prediction
      if (start && !busy) begin
        expected_rots.push_back(rotate_by_quat(
          longint'(in_quat_x), longint'(in_quat_y), longint'(in_quat_z),
          longint'(in_quat_w), longint'(in_vec_x), longint'(in_vec_y),
          longint'(in_vec_z)));
      end
    end
    wait_cnt = expected_rots.size();
  end

endmodule

[sim/quaternion_vector_rotate_tb.sv]
module quaternion_vector_rotate_tb;
  import qvr_pkg::*;

  localparam int DW = 16;
  localparam int PHASE_BEATS = 310;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [DW-1:0] in_quat_x = '0;
  logic signed [DW-1:0] in_quat_y = '0;
  logic signed [DW-1:0] in_quat_z = '0;
  logic signed [DW-1:0] in_quat_w = '0;
  logic signed [DW-1:0] in_vec_x = '0;
  logic signed [DW-1:0] in_vec_y = '0;
  logic signed [DW-1:0] in_vec_z = '0;
  logic                 out_valid;
  logic signed [DW-1:0] out_rot_x;
  logic signed [DW-1:0] out_rot_y;
  logic signed [DW-1:0] out_rot_z;
  logic                 out_saturated;
  int                   mismatch_count;
  int                   pending;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  quaternion_vector_rotate #(.DATA_WIDTH(DW), .FRAC_BITS(14)) i_dut (
    .clk, .rst_n, .start, .busy,
    .in_quat_x, .in_quat_y, .in_quat_z, .in_quat_w,
    .in_vec_x, .in_vec_y, .in_vec_z,
    .out_valid, .out_rot_x, .out_rot_y, .out_rot_z, .out_saturated
  );

  quaternion_vector_rotate_checker #(.DATA_WIDTH(DW), .FRAC_BITS(14)) i_checker (
    .clk, .rst_n, .start, .busy,
    .in_quat_x, .in_quat_y, .in_quat_z, .in_quat_w,
    .in_vec_x, .in_vec_y, .in_vec_z,
    .out_valid, .out_rot_x, .out_rot_y, .out_rot_z, .out_saturated,
    .mismatch_count, .pending
  );

  function automatic logic [DW-1:0] any_word();
    return DW'($urandom_range(0, (1 << DW) - 1));
  endfunction

  function automatic logic [DW-1:0] word_around(input int span);
    return DW'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic drive_rotation(
    input logic [DW-1:0] qx, input logic [DW-1:0] qy, input logic [DW-1:0] qz,
    input logic [DW-1:0] qw, input logic [DW-1:0] vx, input logic [DW-1:0] vy,
    input logic [DW-1:0] vz
  );
    logic was_busy;
    start     <= 1'b1;
    in_quat_x <= qx;
    in_quat_y <= qy;
    in_quat_z <= qz;
    in_quat_w <= qw;
    in_vec_x  <= vx;
    in_vec_y  <= vy;
    in_vec_z  <= vz;
    // busy only moves on a rising edge, so its value now holds through the next one
    do begin
      was_busy = busy;
      @(negedge clk);
    end while (was_busy !== 1'b0);
  endtask

  // sender gaps, with noise on the idle payload
  task automatic hold_off(input int pct);
    while (int'($urandom_range(0, 99)) < pct) begin
      start     <= 1'b0;
      in_quat_x <= any_word();
      in_quat_w <= any_word();
      in_vec_x  <= any_word();
      in_vec_z  <= any_word();
      @(negedge clk);
    end
  endtask

  task automatic random_rotation();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4)
      drive_rotation(any_word(), any_word(), any_word(), any_word(),
                     any_word(), any_word(), any_word());
    else if (kind < 8)
      // roughly unit quaternions over the full vector range
      drive_rotation(word_around(9000), word_around(9000), word_around(9000),
                     word_around(9000), any_word(), any_word(), any_word());
    else
      drive_rotation(word_around(20000), word_around(20000), word_around(20000),
                     word_around(20000), word_around(64), word_around(64),
                     word_around(64));
  endtask

  initial begin
    int idle_pct[3];
    idle_pct = '{0, 51, 18};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identity at the vector extremes
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd32767, 16'sd32767, 16'sd32767);
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd16384, -16'sd32768, -16'sd32768, -16'sd32768);
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd32767, -16'sd32768, 16'sd1);
    // every field at one limit
    drive_rotation(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                   -16'sd32768, -16'sd32768, -16'sd32768);
    drive_rotation(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                   16'sd32767, 16'sd32767, 16'sd32767);
    drive_rotation(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                   -16'sd32768, 16'sd32767, -16'sd32768);
    // zero quaternion
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd1234);
    // quarter turns about each axis, half turn about z, negative axis
    drive_rotation(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'sd1000, 16'sd2000, 16'sd3000);
    drive_rotation(16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 16'sd1000, 16'sd2000, 16'sd3000);
    drive_rotation(16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 16'sd1000, 16'sd2000, 16'sd3000);
    drive_rotation(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd32767, -16'sd32768, 16'sd77);
    drive_rotation(-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd5, 16'sd32767, -16'sd32768);
    // rounding ties, positive and negative
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd8192, 16'sd1, 16'sd3, 16'sd5);
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd8192, -16'sd1, -16'sd3, -16'sd5);
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd2, -16'sd2, 16'sd6);
    // oversized quaternion: clips high, low, and just inside
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd9000, -16'sd9000, 16'sd100);
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd23170, 16'sd16383, -16'sd16384, 16'sd0);
    drive_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd23170, 16'sd16385, -16'sd16385, 16'sd0);

    // random phases: no gaps, heavy gaps, light gaps; a gap-free stretch in each
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ((n % 50) < 40)
          hold_off(idle_pct[ph]);
        random_rotation();
      end
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
    if (mismatch_count == 0 && pending == 0)
      $display("quaternion_vector_rotate_tb: clean");
    else
      $display("quaternion_vector_rotate_tb: errors");
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("quaternion_vector_rotate_tb: errors");
    $finish;
  end

endmodule

[sim.f]
hdl/qvr_pkg.sv
hdl/qvr_lane.sv
hdl/quaternion_vector_rotate.sv
hdl/qvr_checker.sv
sim/quaternion_vector_rotate_checker.sv
sim/quaternion_vector_rotate_tb.sv
